/* design/harris_corner_response_assert.svh */
// Assertion macros used by the Harris corner response RTL.
// All checks are sampled on clk_i and disabled while rst_ni is low.
`ifndef HARRIS_CORNER_RESPONSE_ASSERT_SVH
`define HARRIS_CORNER_RESPONSE_ASSERT_SVH

// Plain property check.
`define HCR_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked in the following cycle.
`define HCR_CHECK_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* design/hcr_pkg.sv */
// ---------------------------------------------------------------------------
// hcr_pkg
// Shared types and constants of the Harris corner response block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hcr_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;

  // Fixed field widths
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned RESP_W  = 48;
  localparam int unsigned COL_W   = 10;
  localparam int unsigned ROW_W   = 16;
  localparam int unsigned K_W     = 16;
  localparam int unsigned IW_W    = 11;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned GRAD_W  = 11;  // signed Sobel gradient
  localparam int unsigned PROD_W  = 22;  // signed gradient product
  localparam int unsigned SUM_W   = 24;  // signed 2x2 sum

  // Configuration register indexes
  localparam logic CFG_K_Q16       = 1'b0;
  localparam logic CFG_IMAGE_WIDTH = 1'b1;

  localparam logic [K_W-1:0]  K_RESET  = 16'd2621;
  localparam logic [IW_W-1:0] IW_RESET = 11'd640;

  // Per-pixel sequencer states
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_SUM  = 7'b0001000,
    S_DET  = 7'b0010000,
    S_KT   = 7'b0100000,
    S_OUT  = 7'b1000000
  } hcr_state_e;

  // Control from the sequencer to the product accumulator
  typedef struct packed {
    logic rd;        // read previous gradient row
    logic mul;       // register current products
    logic sum;       // form sums, write back current products
    logic row_ge2;   // gradient row above exists
    logic gc_zero;   // first gradient column
  } hcr_acc_ctl_t;

  // Control from the sequencer to the pixel window
  typedef struct packed {
    logic rd;        // read line memories
    logic load;      // update window, write back line memories
    logic row_ge2;   // two rows above exist
    logic col_zero;  // first column of a row
  } hcr_win_ctl_t;

endpackage

`default_nettype wire

/* design/hcr_if.sv */
// ---------------------------------------------------------------------------
// hcr_in_if / hcr_out_if
// Valid/ready channels for pixels in and responses out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface hcr_in_if;
  logic                      valid;
  logic                      ready;
  logic [hcr_pkg::PIX_W-1:0] pixel;
  logic                      frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface hcr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [hcr_pkg::RESP_W-1:0] response;
  logic [hcr_pkg::COL_W-1:0]         col;
  logic [hcr_pkg::ROW_W-1:0]         row;

  modport source (output valid, output response, output col, output row, input ready);
  modport sink   (input valid, input response, input col, input row, output ready);
endinterface

`default_nettype wire

/* design/harris_corner_response.sv */
// ---------------------------------------------------------------------------
// harris_corner_response
// Harris corner response over a raster stream of 8-bit grey pixels.
// ---------------------------------------------------------------------------
// Usage:
//   in_i takes one pixel per transfer in raster order; frame_start marks
//   row 0, column 0. out_o gives a signed 48-bit response with the column
//   and row of the pixel it belongs to. Pixel (R, C), R >= 1 and C >= 1,
//   yields the response of (R-1, C-1); other pixels yield nothing, so the
//   last row and last column of a frame give no response.
//   A pixel that yields no response passes the read step only; one that
//   does passes read, products, sums, two multiply stages and output, set
//   by the read-modify-write of the pixel and product line memories and
//   the multiplier chain. The output register holds a finished response
//   while the next pixel is taken in; the final stage waits while the
//   receiver stalls with a response still held. Configuration (k_q16
//   index 0, image_width index 1) is written through cfg_we_i / cfg_idx_i
//   / cfg_data_i by the user only while the block is idle; not enforced.
//   Reset clears counters, window and column sums; line memories need no
//   clearing pass and hold unknown data until written.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "harris_corner_response_assert.svh"

module harris_corner_response #(
  parameter int unsigned MAX_WIDTH = hcr_pkg::MAX_WIDTH_DEF
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  hcr_in_if.sink                      in_i,
  hcr_out_if.source                   out_o,
  input  wire                         cfg_we_i,
  input  wire                         cfg_idx_i,
  input  wire [hcr_pkg::CFG_W-1:0]    cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = AW + 1;
  localparam int unsigned RW = hcr_pkg::RESP_W;
  localparam int unsigned SW = hcr_pkg::SUM_W;

  hcr_pkg::hcr_state_e           state_q, state_d;
  logic [hcr_pkg::K_W-1:0]       k_q;
  logic [hcr_pkg::IW_W-1:0]      iw_q;
  logic [AW-1:0]                 col_q, c_now, c_q;
  logic [hcr_pkg::ROW_W-1:0]     row_q, r_now, r_q;
  logic [WW-1:0]                 eff_w;
  logic                          accept;
  logic [hcr_pkg::PIX_W-1:0]     pix_q;
  logic signed [hcr_pkg::GRAD_W-1:0] gx, gy;
  logic signed [SW-1:0]          sums [3];
  logic signed [RW-1:0]          ac_q, bb_q, det_q;
  logic [RW-1:0]                 tr2_q, kt_q;
  logic [SW-1:0]                 tr;
  logic [RW+hcr_pkg::K_W-1:0]    ktf;
  logic                          out_free;
  hcr_pkg::hcr_win_ctl_t         win_ctl;
  hcr_pkg::hcr_acc_ctl_t         acc_ctl;

  // Effective width, clamped to 3..MAX_WIDTH
  always_comb begin
    if (iw_q < 11'd3) begin
      eff_w = WW'(3);
    end else if (32'(iw_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(iw_q);
    end
  end

  // Position of the incoming pixel
  always_comb begin
    logic [AW-1:0] cs;
    cs    = in_i.frame_start ? '0 : col_q;
    r_now = in_i.frame_start ? '0 : row_q;
    c_now = ({1'b0, cs} >= eff_w) ? AW'(eff_w - WW'(1)) : cs;
  end

  assign accept      = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == hcr_pkg::S_IDLE);
  assign out_free    = !out_o.valid || out_o.ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q  <= hcr_pkg::K_RESET;
      iw_q <= hcr_pkg::IW_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hcr_pkg::CFG_K_Q16:       k_q  <= cfg_data_i;
        hcr_pkg::CFG_IMAGE_WIDTH: iw_q <= cfg_data_i[hcr_pkg::IW_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      hcr_pkg::S_IDLE: if (accept) state_d = hcr_pkg::S_READ;
      hcr_pkg::S_READ: begin
        state_d = (r_q != '0 && c_q != '0) ? hcr_pkg::S_MUL : hcr_pkg::S_IDLE;
      end
      hcr_pkg::S_MUL:  state_d = hcr_pkg::S_SUM;
      hcr_pkg::S_SUM:  state_d = hcr_pkg::S_DET;
      hcr_pkg::S_DET:  state_d = hcr_pkg::S_KT;
      hcr_pkg::S_KT:   state_d = hcr_pkg::S_OUT;
      hcr_pkg::S_OUT:  if (out_free) state_d = hcr_pkg::S_IDLE;
      default:         state_d = hcr_pkg::S_IDLE;
    endcase
  end

  // Advance state and position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hcr_pkg::S_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      c_q     <= '0;
      r_q     <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        c_q <= c_now;
        r_q <= r_now;
        if ((WW'(c_now) + WW'(1)) >= eff_w) begin
          col_q <= '0;
          row_q <= r_now + 1'b1;
        end else begin
          col_q <= c_now + 1'b1;
          row_q <= r_now;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= in_i.pixel;
    end
  end

  // Control to the pixel window
  assign win_ctl.rd       = accept;
  assign win_ctl.load     = (state_q == hcr_pkg::S_READ);
  assign win_ctl.row_ge2  = (r_q > 16'd1);
  assign win_ctl.col_zero = (c_q == '0);

  // Control to the product accumulator
  assign acc_ctl.rd      = (state_q == hcr_pkg::S_READ);
  assign acc_ctl.mul     = (state_q == hcr_pkg::S_MUL);
  assign acc_ctl.sum     = (state_q == hcr_pkg::S_SUM);
  assign acc_ctl.row_ge2 = (r_q > 16'd1);
  assign acc_ctl.gc_zero = (c_q == AW'(1));

  hcr_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (win_ctl),
    .addr_i  (accept ? c_now : c_q),
    .pixel_i (pix_q),
    .gx_o    (gx),
    .gy_o    (gy)
  );

  hcr_accum #(.MAX_WIDTH(MAX_WIDTH)) u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (acc_ctl),
    .addr_i (c_q - AW'(1)),
    .gx_i   (gx),
    .gy_i   (gy),
    .sum_o  (sums)
  );

  // Response arithmetic
  assign tr  = SW'(sums[0] + sums[2]);
  assign ktf = tr2_q * k_q + (RW+hcr_pkg::K_W)'(32768);

  always_ff @(posedge clk_i) begin
    if (state_q == hcr_pkg::S_DET) begin
      ac_q  <= RW'(sums[0] * sums[2]);
      bb_q  <= RW'(sums[1] * sums[1]);
      tr2_q <= RW'(tr * tr);
    end
    if (state_q == hcr_pkg::S_KT) begin
      det_q <= ac_q - bb_q;
      kt_q  <= ktf[RW+hcr_pkg::K_W-1:hcr_pkg::K_W];
    end
  end

  // Output register: load on the final stage, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_o.valid <= 1'b0;
    end else if (state_q == hcr_pkg::S_OUT && out_free) begin
      out_o.valid <= 1'b1;
    end else if (out_o.ready) begin
      out_o.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == hcr_pkg::S_OUT && out_free) begin
      out_o.response <= det_q - $signed(kt_q);
      out_o.col      <= hcr_pkg::COL_W'(c_q - AW'(1));
      out_o.row      <= r_q - 1'b1;
    end
  end

  `HCR_CHECK_NEXT(a_accept_reads, accept, state_q == hcr_pkg::S_READ,
                  "accept must start a read")
  `HCR_CHECK(a_out_from_final, $rose(out_o.valid) |-> $past(state_q == hcr_pkg::S_OUT),
             "response without final stage")
  `HCR_CHECK_NEXT(a_out_hold, out_o.valid && !out_o.ready,
                  out_o.valid && $stable(out_o.response) && $stable(out_o.col)
                  && $stable(out_o.row), "response changed while stalled")

endmodule

`default_nettype wire

/* design/hcr_window.sv */
// ---------------------------------------------------------------------------
// hcr_window
// Pixel line memory for two rows, the 3x3 pixel window and the Sobel gradients.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hcr_window #(
  parameter int unsigned MAX_WIDTH = hcr_pkg::MAX_WIDTH_DEF,
  localparam int unsigned AW = $clog2(MAX_WIDTH)
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire hcr_pkg::hcr_win_ctl_t        ctl_i,
  input  wire [AW-1:0]                      addr_i,
  input  wire [hcr_pkg::PIX_W-1:0]          pixel_i,
  output logic signed [hcr_pkg::GRAD_W-1:0] gx_o,
  output logic signed [hcr_pkg::GRAD_W-1:0] gy_o
);

  localparam int unsigned PW = hcr_pkg::PIX_W;

  // Line memory: upper byte is two rows up, lower byte is one row up
  logic [2*PW-1:0] line_mem [MAX_WIDTH];
  logic [2*PW-1:0] line_rd_q;
  logic [PW-1:0]   mid, top;

  // Window: [column oldest..newest][row top..bottom]
  logic [PW-1:0] win_q [3][3];

  assign mid = line_rd_q[PW-1:0];
  assign top = ctl_i.row_ge2 ? line_rd_q[2*PW-1:PW] : mid;

  // Read line entry, write back the shifted column
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      line_rd_q <= line_mem[addr_i];
    end
    if (ctl_i.load) begin
      line_mem[addr_i] <= {mid, pixel_i};
    end
  end

  // Shift window, or replicate the column at a row start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (ctl_i.load) begin
      for (int i = 0; i < 2; i++) begin
        win_q[i][0] <= ctl_i.col_zero ? top     : win_q[i+1][0];
        win_q[i][1] <= ctl_i.col_zero ? mid     : win_q[i+1][1];
        win_q[i][2] <= ctl_i.col_zero ? pixel_i : win_q[i+1][2];
      end
      win_q[2][0] <= top;
      win_q[2][1] <= mid;
      win_q[2][2] <= pixel_i;
    end
  end

  // Sobel gradients
  always_comb begin
    logic signed [hcr_pkg::GRAD_W-1:0] rgt, lft, bot, upr;
    rgt = $signed({3'b0, win_q[2][0]}) + $signed({2'b0, win_q[2][1], 1'b0})
        + $signed({3'b0, win_q[2][2]});
    lft = $signed({3'b0, win_q[0][0]}) + $signed({2'b0, win_q[0][1], 1'b0})
        + $signed({3'b0, win_q[0][2]});
    bot = $signed({3'b0, win_q[0][2]}) + $signed({2'b0, win_q[1][2], 1'b0})
        + $signed({3'b0, win_q[2][2]});
    upr = $signed({3'b0, win_q[0][0]}) + $signed({2'b0, win_q[1][0], 1'b0})
        + $signed({3'b0, win_q[2][0]});
    gx_o = rgt - lft;
    gy_o = bot - upr;
  end

endmodule

`default_nettype wire

/* design/hcr_accum.sv */
// ---------------------------------------------------------------------------
// hcr_accum
// Gradient products, their line memory and the 2x2 window sums.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hcr_accum #(
  parameter int unsigned MAX_WIDTH = hcr_pkg::MAX_WIDTH_DEF,
  localparam int unsigned AW = $clog2(MAX_WIDTH)
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire hcr_pkg::hcr_acc_ctl_t        ctl_i,
  input  wire [AW-1:0]                      addr_i,
  input  wire signed [hcr_pkg::GRAD_W-1:0]  gx_i,
  input  wire signed [hcr_pkg::GRAD_W-1:0]  gy_i,
  output logic signed [hcr_pkg::SUM_W-1:0]  sum_o [3]
);

  localparam int unsigned PW = hcr_pkg::PROD_W;
  localparam int unsigned SW = hcr_pkg::SUM_W;

  logic [3*PW-1:0]           prod_mem [MAX_WIDTH];
  logic [3*PW-1:0]           prod_rd_q;
  logic signed [PW-1:0]      cur_q  [3];
  logic signed [SW-2:0]      vcol_q [3];
  logic signed [SW-1:0]      sum_q  [3];
  logic signed [2*hcr_pkg::GRAD_W-1:0] pxx, pxy, pyy;

  assign pxx = gx_i * gx_i;
  assign pxy = gx_i * gy_i;
  assign pyy = gy_i * gy_i;

  // Read the row above, write back the current products
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      prod_rd_q <= prod_mem[addr_i];
    end
    if (ctl_i.sum) begin
      prod_mem[addr_i] <= {cur_q[2], cur_q[1], cur_q[0]};
    end
  end

  // Hold the current products
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) begin
      cur_q[0] <= PW'(pxx);
      cur_q[1] <= PW'(pxy);
      cur_q[2] <= PW'(pyy);
    end
  end

  // Vertical then horizontal sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        vcol_q[i] <= '0;
        sum_q[i]  <= '0;
      end
    end else if (ctl_i.sum) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [PW-1:0]   up;
        logic signed [SW-2:0]   vert;
        up   = ctl_i.row_ge2 ? $signed(prod_rd_q[i*PW +: PW]) : cur_q[i];
        vert = (SW-1)'(up) + (SW-1)'(cur_q[i]);
        sum_q[i]  <= ctl_i.gc_zero ? SW'(vert) + SW'(vert)
                                   : SW'(vcol_q[i]) + SW'(vert);
        vcol_q[i] <= vert;
      end
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for harris_corner_response: frames of pixels go in
// over valid/ready with random idle cycles on both sides, each response is
// compared against an in-bench Sobel/Harris predictor, config is changed
// between frames.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

import hcr_pkg::*;

typedef struct {
  logic signed [RESP_W-1:0] response;
  logic [COL_W-1:0]         col;
  logic [ROW_W-1:0]         row;
} corner_resp_t;

class corner_scoreboard;
  corner_resp_t exp_q[$];
  int unsigned  errors;

  // predictor state
  logic [K_W-1:0]  k_q;
  logic [IW_W-1:0] width_q;
  logic [7:0]      line_a [1024];
  logic [7:0]      line_b [1024];
  int              gxx_line [1024];
  int              gxy_line [1024];
  int              gyy_line [1024];
  int              win [3][3];  // [column old..new][row top..bottom]
  int              col_prods [3];
  int unsigned     col_cnt;
  int unsigned     row_cnt;

  function new();
    k_q      = K_RESET;
    width_q  = IW_RESET;
    col_cnt  = 0;
    row_cnt  = 0;
    errors   = 0;
    foreach (win[i, j]) win[i][j] = 0;
    foreach (col_prods[i]) col_prods[i] = 0;
  endfunction

  function void write_reg(logic idx, logic [CFG_W-1:0] data);
    if (idx == CFG_K_Q16) k_q = data[K_W-1:0];
    else width_q = data[IW_W-1:0];
  endfunction

  // Advance the predictor by one accepted pixel transfer.
  function void note_pixel(logic [7:0] px, logic fs);
    int unsigned     w, c, r, gc;
    int              top, mid, gx, gy;
    int              cur [3];
    int              up [3];
    int              vert [3];
    int              sum [3];
    longint          det;
    longint unsigned tr, kt;
    corner_resp_t    e;
    w = (width_q < 3) ? 3 : (width_q > 1024) ? 1024 : width_q;
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    if (col_cnt >= w) col_cnt = w - 1;
    c = col_cnt;
    r = row_cnt;
    mid = line_a[c];
    top = (r >= 2) ? line_b[c] : mid;
    line_b[c] = mid[7:0];
    line_a[c] = px;
    // shift the window, or fill it on the first column
    if (c == 0) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] = top; win[i][1] = mid; win[i][2] = px;
      end
    end else begin
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 3; j++) win[i][j] = win[i+1][j];
      win[2][0] = top; win[2][1] = mid; win[2][2] = px;
    end
    if (r >= 1 && c >= 1) begin
      gc = c - 1;
      gx = (win[2][0] + 2*win[2][1] + win[2][2]) - (win[0][0] + 2*win[0][1] + win[0][2]);
      gy = (win[0][2] + 2*win[1][2] + win[2][2]) - (win[0][0] + 2*win[1][0] + win[2][0]);
      cur[0] = gx*gx; cur[1] = gx*gy; cur[2] = gy*gy;
      if (r >= 2) begin
        up[0] = gxx_line[gc]; up[1] = gxy_line[gc]; up[2] = gyy_line[gc];
      end else begin
        up = cur;
      end
      gxx_line[gc] = cur[0]; gxy_line[gc] = cur[1]; gyy_line[gc] = cur[2];
      for (int i = 0; i < 3; i++) begin
        vert[i] = up[i] + cur[i];
        sum[i] = (gc == 0) ? 2*vert[i] : col_prods[i] + vert[i];
        col_prods[i] = vert[i];
      end
      det = longint'(sum[0])*longint'(sum[2]) - longint'(sum[1])*longint'(sum[1]);
      tr = longint'(sum[0]) + longint'(sum[2]);
      kt = ((tr*tr)*longint'(k_q) + 64'd32768) >> 16;
      e.response = det - longint'(kt);
      e.col = gc[COL_W-1:0];
      e.row = 16'(r - 1);
      exp_q.push_back(e);
    end
    if (c + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1) & 32'hFFFF;
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  // Compare one response transfer with the oldest expectation.
  function void check_response(logic signed [RESP_W-1:0] resp, logic [COL_W-1:0] col,
                               logic [ROW_W-1:0] row);
    corner_resp_t e;
    if (exp_q.size() == 0) begin
      $error("unexpected response %0d at col %0d row %0d", resp, col, row);
      errors++;
      return;
    end
    e = exp_q.pop_front();
    if (resp !== e.response) begin
      $error("response: expected %0d, actual %0d", e.response, resp); errors++;
    end
    if (col !== e.col) begin
      $error("col: expected %0d, actual %0d", e.col, col); errors++;
    end
    if (row !== e.row) begin
      $error("row: expected %0d, actual %0d", e.row, row); errors++;
    end
  endfunction
endclass

module tb_top;
  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_idx;
  logic [CFG_W-1:0] cfg_data;
  bit               stall_on;

  corner_scoreboard sb;

  hcr_in_if  in_if ();
  hcr_out_if out_if ();

  harris_corner_response i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  // Stall the response channel at random
  initial out_if.ready = 1'b0;
  always @(posedge clk) begin
    out_if.ready <= stall_on ? ($urandom_range(99) >= 17) : 1'b1;
  end

  // Sample response transfers mid-cycle, away from the driving edge
  always @(negedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_response(out_if.response, out_if.col, out_if.row);
  end

  task automatic send_pixel(logic [7:0] px, logic fs);
    logic rdy;
    if (stall_on && $urandom_range(99) < 17) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.pixel       <= px;
    in_if.frame_start <= fs;
    do begin
      @(negedge clk);
      rdy = in_if.ready;
      @(posedge clk);
    end while (!rdy);
    sb.note_pixel(px, fs);
  endtask

  // Drain outstanding responses, then let the pipeline settle
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.exp_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // One frame: mode 0 random, 1 black/white, 2 ramp, 3 vertical edge, 4 horizontal edge
  task automatic send_frame(int unsigned w, int unsigned rows, int unsigned mode,
                            bit noise);
    logic [7:0] px;
    logic       fs;
    for (int unsigned r = 0; r < rows; r++) begin
      for (int unsigned c = 0; c < w; c++) begin
        case (mode)
          0: px = 8'($urandom);
          1: px = $urandom_range(1) ? 8'hFF : 8'h00;
          2: px = 8'(r*7 + c*13);
          3: px = (c % 3 == 2) ? 8'hFF : 8'h00;
          default: px = (r % 3 == 2) ? 8'hFF : 8'h00;
        endcase
        fs = (r == 0 && c == 0) || (noise && $urandom_range(59) == 0);
        send_pixel(px, fs);
      end
    end
  endtask

  initial begin
    int unsigned      total, w_eff, w_val, rows;
    logic [CFG_W-1:0] k_val;
    bit               big_done;
    sb = new();
    rst_n             = 1'b0;
    stall_on          = 1'b1;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_K_Q16;
    cfg_data          = '0;
    in_if.valid       = 1'b0;
    in_if.pixel       = '0;
    in_if.frame_start = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    // Directed: narrow frames with full-scale edges, k at both extremes,
    // width below the minimum, and a frame start in mid-row
    write_reg(CFG_IMAGE_WIDTH, 16'd2);
    write_reg(CFG_K_Q16, 16'd0);
    send_frame(3, 3, 3, 1'b0);
    wait_idle();
    write_reg(CFG_K_Q16, 16'hFFFF);
    send_frame(3, 3, 4, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b1);
    send_frame(3, 2, 1, 1'b0);
    wait_idle();

    // Random frames with changing settings
    total    = 0;
    big_done = 0;
    while (total < 1850) begin
      case ($urandom_range(7))
        0: k_val = 16'd0;
        1: k_val = 16'hFFFF;
        default: k_val = 16'($urandom);
      endcase
      case ($urandom_range(9))
        0: w_val = $urandom_range(2);
        1: w_val = big_done ? 3 : ($urandom_range(1) ? 1024 : 2047);
        2: w_val = 3;
        default: w_val = $urandom_range(4, 16);
      endcase
      w_eff = (w_val < 3) ? 3 : (w_val > 1024) ? 1024 : w_val;
      if (w_eff == 1024) big_done = 1;
      rows = (w_eff == 1024) ? 2 : $urandom_range(2, 8);
      write_reg(CFG_K_Q16, k_val);
      write_reg(CFG_IMAGE_WIDTH, {5'($urandom), w_val[IW_W-1:0]});
      stall_on = !(total > 700 && total < 1000);
      send_frame(w_eff, rows, $urandom_range(4) < 3 ? 0 : $urandom_range(1, 4),
                 w_eff < 1024);
      total += w_eff * rows;
      wait_idle();
    end

    // Final check
    if (sb.exp_q.size() != 0) begin
      $error("%0d expected responses never arrived", sb.exp_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
